// ===== hdl/indexed_array_table_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Indexed array table engine assertion macros
// Shared forms for the concurrent checks on the engine's ports.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_TABLE_ENGINE_ASSERT_SVH
`define INDEXED_ARRAY_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IATE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: label");

// Next-cycle implication, disabled during reset.
`define IATE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: label");

`endif

// ===== hdl/iate_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed array table engine package
// Sizes, opcodes, status codes and sequencer states shared by the design.
// ----------------------------------------------------------------------------
package iate_pkg;

   localparam int DEPTH     = 1024;
   localparam int WORD_BITS = 32;
   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int OP_BITS   = 3;
   localparam int ST_BITS   = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE = 3'd1,
      OP_GET    = 3'd2,
      OP_SET    = 3'd3,
      OP_FIND   = 3'd4,
      OP_SORT   = 3'd5
   } op_type;

   localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [ST_BITS-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_BITS-1:0] ST_FULL  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_MV,
      S_INS_PUT,
      S_REM_GET,
      S_REM_MV,
      S_GET,
      S_FIND,
      S_SORT_LD,
      S_SORT_CMP,
      S_SORT_END,
      S_DONE
   } state_type;

endpackage

// ===== hdl/iate_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one engine request.
// ----------------------------------------------------------------------------
interface iate_req_if import iate_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [OP_BITS-1:0]          opcode;
   logic [CNT_BITS-1:0]         position;
   logic signed [WORD_BITS-1:0] word_in;

   modport source (output valid, opcode, position, word_in, input ready);
   modport sink   (input valid, opcode, position, word_in, output ready);
endinterface

// ===== hdl/iate_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one engine response.
// ----------------------------------------------------------------------------
interface iate_rsp_if import iate_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] word_out;
   logic signed [CNT_BITS-1:0]  found_index;
   logic [ST_BITS-1:0]          op_status;
   logic [CNT_BITS-1:0]         entry_count;

   modport source (output valid, word_out, found_index, op_status, entry_count,
                   input ready);
   modport sink   (input valid, word_out, found_index, op_status, entry_count,
                   output ready);
endinterface

// ===== hdl/indexed_array_table_engine.sv =====
// ----------------------------------------------------------------------------
// Indexed array table engine
// Ordered store of signed words with insert, remove, get, set, find and sort.
// ----------------------------------------------------------------------------
// One request is worked at a time; a new request is taken once the previous
// one has placed its response in the output register, even while that
// response still waits. All entries live in one single-port-write,
// single-port-read memory with a registered read, and insert, remove, find
// and sort walk that memory one entry per cycle (n is the entry count).
// Sort is a bubble sort of n - 1 passes, each over the whole store. There
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
module indexed_array_table_engine import iate_pkg::*; (
   input logic       clock,
   input logic       reset,
   iate_req_if.sink  req_channel,
   iate_rsp_if.source rsp_channel
);

   // Entry memory.
   logic signed [WORD_BITS-1:0] mem [DEPTH];
   logic signed [WORD_BITS-1:0] mem_q;
   logic                        mem_we;
   logic [IDX_BITS-1:0]         mem_waddr;
   logic signed [WORD_BITS-1:0] mem_wdata;
   logic                        mem_re;
   logic [IDX_BITS-1:0]         mem_raddr;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0]         count_ff, count_in;
   logic [CNT_BITS-1:0]         j_ff, j_in;
   logic [CNT_BITS-1:0]         k_ff, k_in;
   logic [CNT_BITS-1:0]         pos_ff, pos_in;
   logic signed [WORD_BITS-1:0] word_ff, word_in;
   logic signed [WORD_BITS-1:0] cur_ff, cur_in;
   logic signed [WORD_BITS-1:0] res_word_ff, res_word_in;
   logic signed [CNT_BITS-1:0]  res_found_ff, res_found_in;
   logic [ST_BITS-1:0]          res_status_ff, res_status_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_BITS-1:0] rsp_word_ff;
   logic signed [CNT_BITS-1:0]  rsp_found_ff;
   logic [ST_BITS-1:0]          rsp_status_ff;
   logic [CNT_BITS-1:0]         rsp_count_ff;

   logic req_fire;
   logic rsp_load;
   logic sort_gt;
   logic find_hit;

   assign req_channel.ready = (state_ff == S_IDLE);
   assign req_fire          = req_channel.valid && req_channel.ready;
   assign rsp_load          = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_channel.ready);
   assign sort_gt           = (cur_ff > mem_q);
   assign find_hit          = (mem_q == word_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_channel.opcode)
                  OP_INSERT: begin
                     if (req_channel.position > count_ff ||
                         count_ff == CNT_BITS'(DEPTH)) begin
                        state_in = S_DONE;
                     end else if (req_channel.position == count_ff) begin
                        state_in = S_INS_PUT;
                     end else begin
                        state_in = S_INS_MV;
                     end
                  end
                  OP_REMOVE: begin
                     state_in = (req_channel.position >= count_ff) ? S_DONE : S_REM_GET;
                  end
                  OP_GET: begin
                     state_in = (req_channel.position >= count_ff) ? S_DONE : S_GET;
                  end
                  OP_FIND: begin
                     state_in = (count_ff == '0) ? S_DONE : S_FIND;
                  end
                  OP_SORT: begin
                     state_in = (count_ff < CNT_BITS'(2)) ? S_DONE : S_SORT_LD;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_INS_MV: begin
            if (j_ff - CNT_BITS'(1) == pos_ff) begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            state_in = S_DONE;
         end
         S_REM_GET: begin
            state_in = (j_ff + CNT_BITS'(1) < count_ff) ? S_REM_MV : S_DONE;
         end
         S_REM_MV: begin
            if (!(j_ff + CNT_BITS'(2) < count_ff)) begin
               state_in = S_DONE;
            end
         end
         S_GET: begin
            state_in = S_DONE;
         end
         S_FIND: begin
            if (find_hit || !(j_ff + CNT_BITS'(1) < count_ff)) begin
               state_in = S_DONE;
            end
         end
         S_SORT_LD: begin
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            if (!(j_ff + CNT_BITS'(2) < count_ff)) begin
               state_in = S_SORT_END;
            end
         end
         S_SORT_END: begin
            state_in = (k_ff + CNT_BITS'(2) < count_ff) ? S_SORT_LD : S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      count_in      = count_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      cur_in        = cur_ff;
      res_word_in   = res_word_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = j_ff[IDX_BITS-1:0];
      mem_wdata     = mem_q;
      mem_re        = 1'b0;
      mem_raddr     = j_ff[IDX_BITS-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pos_in        = req_channel.position;
               word_in       = req_channel.word_in;
               res_word_in   = '0;
               res_found_in  = '0;
               res_status_in = ST_OK;
               case (req_channel.opcode)
                  OP_INSERT: begin
                     if (req_channel.position > count_ff) begin
                        res_status_in = ST_RANGE;
                     end else if (count_ff == CNT_BITS'(DEPTH)) begin
                        res_status_in = ST_FULL;
                     end else if (req_channel.position != count_ff) begin
                        // Start moving the tail up from the last entry.
                        j_in      = count_ff;
                        mem_re    = 1'b1;
                        mem_raddr = IDX_BITS'(count_ff - CNT_BITS'(1));
                     end
                  end
                  OP_REMOVE, OP_GET: begin
                     if (req_channel.position >= count_ff) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        j_in      = req_channel.position;
                        mem_re    = 1'b1;
                        mem_raddr = req_channel.position[IDX_BITS-1:0];
                     end
                  end
                  OP_SET: begin
                     if (req_channel.position >= count_ff) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = req_channel.position[IDX_BITS-1:0];
                        mem_wdata = req_channel.word_in;
                     end
                  end
                  OP_FIND: begin
                     res_found_in = '1;
                     j_in         = '0;
                     mem_re       = 1'b1;
                     mem_raddr    = '0;
                  end
                  OP_SORT: begin
                     k_in      = '0;
                     mem_re    = 1'b1;
                     mem_raddr = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS_MV: begin
            // Entry j takes entry j - 1, which arrived this cycle.
            mem_we    = 1'b1;
            mem_waddr = j_ff[IDX_BITS-1:0];
            mem_wdata = mem_q;
            if (j_ff - CNT_BITS'(1) != pos_ff) begin
               mem_re    = 1'b1;
               mem_raddr = IDX_BITS'(j_ff - CNT_BITS'(2));
               j_in      = j_ff - CNT_BITS'(1);
            end
         end
         S_INS_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[IDX_BITS-1:0];
            mem_wdata = word_ff;
            count_in  = count_ff + CNT_BITS'(1);
         end
         S_REM_GET: begin
            res_word_in = mem_q;
            if (j_ff + CNT_BITS'(1) < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = IDX_BITS'(j_ff + CNT_BITS'(1));
            end else begin
               count_in = count_ff - CNT_BITS'(1);
            end
         end
         S_REM_MV: begin
            // Entry j takes entry j + 1 while entry j + 2 is read.
            mem_we    = 1'b1;
            mem_waddr = j_ff[IDX_BITS-1:0];
            mem_wdata = mem_q;
            j_in      = j_ff + CNT_BITS'(1);
            if (j_ff + CNT_BITS'(2) < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = IDX_BITS'(j_ff + CNT_BITS'(2));
            end else begin
               count_in = count_ff - CNT_BITS'(1);
            end
         end
         S_GET: begin
            res_word_in = mem_q;
         end
         S_FIND: begin
            if (find_hit) begin
               res_found_in = j_ff;
            end else if (j_ff + CNT_BITS'(1) < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = IDX_BITS'(j_ff + CNT_BITS'(1));
               j_in      = j_ff + CNT_BITS'(1);
            end
         end
         S_SORT_LD: begin
            // The first entry becomes the carried word of this pass.
            cur_in    = mem_q;
            j_in      = '0;
            mem_re    = 1'b1;
            mem_raddr = IDX_BITS'(1);
         end
         S_SORT_CMP: begin
            // Keep the larger word and drop the smaller one at entry j.
            mem_we    = 1'b1;
            mem_waddr = j_ff[IDX_BITS-1:0];
            mem_wdata = sort_gt ? mem_q : cur_ff;
            cur_in    = sort_gt ? cur_ff : mem_q;
            j_in      = j_ff + CNT_BITS'(1);
            if (j_ff + CNT_BITS'(2) < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = IDX_BITS'(j_ff + CNT_BITS'(2));
            end
         end
         S_SORT_END: begin
            mem_we    = 1'b1;
            mem_waddr = IDX_BITS'(count_ff - CNT_BITS'(1));
            mem_wdata = cur_ff;
            if (k_ff + CNT_BITS'(2) < count_ff) begin
               k_in      = k_ff + CNT_BITS'(1);
               mem_re    = 1'b1;
               mem_raddr = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register: loaded from the finished request, drained by the sink.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff          <= j_in;
      k_ff          <= k_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      cur_ff        <= cur_in;
      res_word_ff   <= res_word_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_word_ff   <= res_word_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.word_out    = rsp_word_ff;
   assign rsp_channel.found_index = rsp_found_ff;
   assign rsp_channel.op_status   = rsp_status_ff;
   assign rsp_channel.entry_count = rsp_count_ff;

endmodule

// ===== hdl/iate_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed array table engine checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_array_table_engine_assert.svh"

module iate_checker import iate_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [WORD_BITS-1:0] rsp_word_out,
   input logic signed [CNT_BITS-1:0]  rsp_found_index,
   input logic [ST_BITS-1:0]          rsp_op_status,
   input logic [CNT_BITS-1:0]         rsp_entry_count
);

   // A waiting response stays offered.
   `IATE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A rejected request returns no word.
   `IATE_ASSERT_NOW(a_err_no_word, clock, reset, rsp_valid && rsp_op_status != ST_OK, rsp_word_out == '0)

   // A full store reports the whole capacity in use.
   `IATE_ASSERT_NOW(a_full_count, clock, reset, rsp_valid && rsp_op_status == ST_FULL, rsp_entry_count == CNT_BITS'(DEPTH))

   // A found index lies inside the store.
   `IATE_ASSERT_NOW(a_found_range, clock, reset, rsp_valid && rsp_found_index > 0, rsp_found_index < $signed({1'b0, rsp_entry_count}))

endmodule

bind indexed_array_table_engine iate_checker u_iate_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_channel.valid),
   .rsp_ready       (rsp_channel.ready),
   .rsp_word_out    (rsp_channel.word_out),
   .rsp_found_index (rsp_channel.found_index),
   .rsp_op_status   (rsp_channel.op_status),
   .rsp_entry_count (rsp_channel.entry_count)
);

// ===== sim/tb_indexed_array_table_engine.sv =====
// ----------------------------------------------------------------------------
// Indexed array table engine testbench
// Drives insert, remove, get, set, find and sort requests, with rejected and
// unused ones mixed in, and checks every response against a queue-based
// model of the store. Requests and responses idle at random in several
// phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_indexed_array_table_engine;
   import iate_pkg::*;

   typedef struct {
      logic signed [WORD_BITS-1:0] word_out;
      logic [CNT_BITS-1:0]         found_index;
      logic [ST_BITS-1:0]          op_status;
      logic [CNT_BITS-1:0]         entry_count;
   } engine_rsp_type;

   // Scoreboard: keeps the model store and the responses still to come.
   class table_scoreboard;
      int             entries[$];
      engine_rsp_type pending[$];

      // Works out the response to one accepted request and updates the model.
      function void note_request(logic [OP_BITS-1:0] op, logic [CNT_BITS-1:0] pos,
                                 logic signed [WORD_BITS-1:0] word);
         engine_rsp_type r;
         int             n;
         int             tmp;
         n = entries.size();
         r.word_out    = '0;
         r.found_index = '0;
         r.op_status   = ST_OK;
         case (op)
            OP_INSERT: begin
               if (pos > n) r.op_status = ST_RANGE;
               else if (n >= DEPTH) r.op_status = ST_FULL;
               else entries.insert(int'(pos), int'(word));
            end
            OP_REMOVE: begin
               if (pos >= n) r.op_status = ST_RANGE;
               else begin
                  r.word_out = entries[pos];
                  entries.delete(int'(pos));
               end
            end
            OP_GET: begin
               if (pos >= n) r.op_status = ST_RANGE;
               else r.word_out = entries[pos];
            end
            OP_SET: begin
               if (pos >= n) r.op_status = ST_RANGE;
               else entries[pos] = int'(word);
            end
            OP_FIND: begin
               r.found_index = '1;
               for (int j = 0; j < n; j++) begin
                  if (entries[j] == int'(word)) begin
                     r.found_index = j[CNT_BITS-1:0];
                     break;
                  end
               end
            end
            OP_SORT: begin
               // Signed ascending order, same as the bubble sort leaves it.
               for (int k = 0; k + 1 < n; k++) begin
                  for (int j = 0; j + 1 < n - k; j++) begin
                     if (entries[j] > entries[j+1]) begin
                        tmp          = entries[j];
                        entries[j]   = entries[j+1];
                        entries[j+1] = tmp;
                     end
                  end
               end
            end
            default: ;
         endcase
         r.entry_count = CNT_BITS'(entries.size());
         pending.push_back(r);
      endfunction

      // Compares one response with the oldest expectation; returns 1 on match.
      function bit check_response(engine_rsp_type got, output string why);
         engine_rsp_type want;
         why = "";
         if (pending.size() == 0) begin
            why = "response arrived with no request outstanding";
            return 0;
         end
         want = pending.pop_front();
         if (got.word_out !== want.word_out)
            why = {why, $sformatf(" word_out %0d/%0d", got.word_out, want.word_out)};
         if (got.found_index !== want.found_index)
            why = {why, $sformatf(" found_index %h/%h", got.found_index,
                                  want.found_index)};
         if (got.op_status !== want.op_status)
            why = {why, $sformatf(" op_status %0d/%0d", got.op_status, want.op_status)};
         if (got.entry_count !== want.entry_count)
            why = {why, $sformatf(" entry_count %0d/%0d", got.entry_count,
                                  want.entry_count)};
         return why == "";
      endfunction
   endclass

   logic clock;
   logic reset;
   int   error_count;
   int   send_idle_pct;
   int   rsp_stall_pct;
   int   item_idx;
   table_scoreboard sb;

   iate_req_if req_channel ();
   iate_rsp_if rsp_channel ();

   indexed_array_table_engine u_top (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel.sink),
      .rsp_channel (rsp_channel.source)
   );

   // Clock with a 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report(string what);
      $display("%0t mismatch:%s", $time, what);
      error_count++;
   endtask

   // Drives one request and holds it until the engine accepts it.
   task automatic send_request(logic [OP_BITS-1:0] op, logic [CNT_BITS-1:0] pos,
                               logic signed [WORD_BITS-1:0] word);
      int gap;
      req_channel.valid    <= 1'b1;
      req_channel.opcode   <= op;
      req_channel.position <= pos;
      req_channel.word_in  <= word;
      do @(posedge clock); while (!req_channel.ready);
      sb.note_request(op, pos, word);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 12) gap++;
      if (gap > 0) begin
         req_channel.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Picks a word, often from a small pool so that finds and sorts hit ties.
   function automatic logic signed [WORD_BITS-1:0] pick_word();
      logic signed [WORD_BITS-1:0] pool[8];
      pool = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 5, -7, 32'sh1234_5678};
      if ($urandom_range(1)) return pool[$urandom_range(7)];
      return $urandom;
   endfunction

   // Random request, mostly well formed, keeping the store small.
   task automatic random_request();
      int n;
      int r;
      logic [OP_BITS-1:0] op;
      logic [CNT_BITS-1:0] pos;
      n = sb.entries.size();
      r = $urandom_range(99);
      if (n < 3 && r < 60) r = 0;
      if (n > 40 && r < 30) r = 35;
      if (r < 30) op = OP_INSERT;
      else if (r < 50) op = OP_REMOVE;
      else if (r < 62) op = OP_GET;
      else if (r < 72) op = OP_SET;
      else if (r < 86) op = OP_FIND;
      else if (r < 92) op = OP_SORT;
      else op = OP_BITS'(3'd6 + $urandom_range(1));
      if ($urandom_range(99) < 6) pos = CNT_BITS'($urandom_range(DEPTH));
      else if (op == OP_INSERT) pos = CNT_BITS'($urandom_range(n));
      else if (n > 0) pos = CNT_BITS'($urandom_range(n - 1));
      else pos = CNT_BITS'($urandom_range(3));
      send_request(op, pos, pick_word());
   endtask

   // Response side: checks accepted responses and stalls at random.
   always @(posedge clock) begin
      engine_rsp_type got;
      string          why;
      if (reset) begin
         rsp_channel.ready <= 1'b0;
      end else begin
         if (rsp_channel.valid && rsp_channel.ready) begin
            got.word_out    = rsp_channel.word_out;
            got.found_index = rsp_channel.found_index;
            got.op_status   = rsp_channel.op_status;
            got.entry_count = rsp_channel.entry_count;
            if (!sb.check_response(got, why)) report(why);
         end
         rsp_channel.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog for a hung engine.
   initial begin
      #100ms;
      $display("tb_indexed_array_table_engine failed");
      $finish;
   end

   // Main sequence.
   initial begin
      sb = new();
      error_count   = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      reset = 1'b1;
      req_channel.valid    = 1'b0;
      req_channel.opcode   = '0;
      req_channel.position = '0;
      req_channel.word_in  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests on an empty and then a small store.
      send_request(OP_FIND, 0, 0);
      send_request(OP_SORT, 0, 0);
      send_request(OP_GET, 0, 0);
      send_request(OP_REMOVE, 0, 0);
      send_request(OP_SET, 0, 1);
      send_request(OP_INSERT, 1, 3);
      send_request(OP_INSERT, 0, 32'sh7fff_ffff);
      send_request(OP_INSERT, 1, 32'sh8000_0000);
      send_request(OP_INSERT, 1, -1);
      send_request(OP_INSERT, 4, 9);
      send_request(OP_INSERT, DEPTH, 9);
      send_request(OP_GET, 2, 0);
      send_request(OP_GET, 3, 0);
      send_request(OP_SET, 1, 0);
      send_request(OP_FIND, 0, 32'sh8000_0000);
      send_request(OP_FIND, 0, 12345);
      send_request(3'd6, 5, 1);
      send_request(3'd7, 2047, -1);
      send_request(OP_SORT, 0, 0);
      send_request(OP_GET, 0, 0);
      send_request(OP_REMOVE, 1, 0);
      send_request(OP_REMOVE, 2, 0);
      send_request(OP_SORT, 0, 0);

      // Random requests in four idling phases.
      for (item_idx = 0; item_idx < 580; item_idx++) begin
         case (item_idx / 145)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin send_idle_pct = 16; rsp_stall_pct = 16; end
         endcase
         random_request();
      end
      req_channel.valid <= 1'b0;

      // Drain the outstanding responses.
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_indexed_array_table_engine passed");
      end else begin
         $display("tb_indexed_array_table_engine failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/iate_pkg.sv
hdl/iate_req_if.sv
hdl/iate_rsp_if.sv
hdl/indexed_array_table_engine.sv
hdl/iate_checker.sv
sim/tb_indexed_array_table_engine.sv
